// ===== design/sfr_crc16_pkg.sv =====
// shared constants for the serial frame receiver: widths, status codes,
// frame phase codes, register indexes and reset values; no dependencies
package sfr_crc16_pkg;

	localparam int CRC_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int CHAR_W  = 7;
	localparam int STAT_W  = 3;
	localparam int PHASE_W = 3;
	localparam int BITPOS_W = 3;
	localparam int CFG_IDX_W = 1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_PAYLOAD   = 3'd0;
	localparam logic [STAT_W-1:0] ST_CRC_PASS  = 3'd1;
	localparam logic [STAT_W-1:0] ST_CRC_FAIL  = 3'd2;
	localparam logic [STAT_W-1:0] ST_PARITY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_SYNC_MISS = 3'd4;

	// frame phase codes
	localparam logic [PHASE_W-1:0] PH_SYNC1 = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SYNC2 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SEQ   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LEN   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_CHAR = 1'd1;

	localparam logic [CRC_W-1:0]  CRC_POLY_RST  = 16'h8005;
	localparam logic [CHAR_W-1:0] SYNC_CHAR_RST = 7'd22;

endpackage

// ===== design/serial_frame_receiver_crc16_core.sv =====
// serial frame receiver top level: byte assembly, header checks, crc-16 check
// depends on sfr_crc16_pkg and sfr_crc16_byte
//
// channel   direction  handshake               payload
// bit       in         bit_valid / bit_stall   line_bit
// result    out        result_valid / result_stall
//                                               status, data_byte, byte_index, data_valid,
//                                               frame_end, sequence_number, frame_length
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one line bit is taken per cycle while bit_stall is low; a completed byte passes through
// the input register and then the single framing/crc stage into the result register
// a result appears only on the eighth bit of a byte, at most one per byte
// arst_n clears the framer state and valid flags and resets the config registers at once
// a result held under result_stall holds the framing stage and stalls the bit channel
// cfg_ready is always high
module serial_frame_receiver_crc16_core import sfr_crc16_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bit_valid,
	output logic                 bit_stall,
	input  logic                 line_bit,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [STAT_W-1:0]    status,
	output logic [BYTE_W-1:0]    data_byte,
	output logic [CHAR_W-1:0]    byte_index,
	output logic                 data_valid,
	output logic                 frame_end,
	output logic [CHAR_W-1:0]    sequence_number,
	output logic [CHAR_W-1:0]    frame_length,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data
);

	// configuration registers
	logic [CRC_W-1:0]  crc_poly_q;
	logic [CHAR_W-1:0] sync_char_q;

	// input register
	logic valid_s1;
	logic bit_s1;

	// framer state
	logic [BITPOS_W-1:0] bit_pos_q;
	logic [BYTE_W-1:0]   shifter_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CHAR_W-1:0]   held_seq_q;
	logic [CHAR_W-1:0]   held_len_q;
	logic [CHAR_W-1:0]   count_q;
	logic [CRC_W-1:0]    crc_q;

	// result register
	logic                result_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [BYTE_W-1:0]   data_byte_q;
	logic [CHAR_W-1:0]   byte_index_q;
	logic                data_valid_q;
	logic                frame_end_q;
	logic [CHAR_W-1:0]   seq_q;
	logic [CHAR_W-1:0]   len_q;

	// next-state and result from the framing stage
	logic                advance;
	logic [BYTE_W-1:0]   shifter_next;
	logic [CRC_W-1:0]    crc_upd;
	logic                parity_ok;
	logic                sync_hit;
	logic [PHASE_W-1:0]  phase_next;
	logic [CHAR_W-1:0]   held_seq_next;
	logic [CHAR_W-1:0]   held_len_next;
	logic [CHAR_W-1:0]   count_next;
	logic [CRC_W-1:0]    crc_next;
	logic                res_hit;
	logic [STAT_W-1:0]   res_status;
	logic [BYTE_W-1:0]   res_data;
	logic [CHAR_W-1:0]   res_index;
	logic                res_dvalid;
	logic                res_end;
	logic [CHAR_W-1:0]   res_seq;
	logic [CHAR_W-1:0]   res_len;
	logic [CHAR_W-1:0]   count_inc;

	// the framing stage moves unless a result is held by the consumer
	assign advance   = !(result_valid_q && result_stall);
	assign bit_stall = !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q  <= CRC_POLY_RST;
			sync_char_q <= SYNC_CHAR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CRC_POLY:  crc_poly_q  <= cfg_data;
				REG_SYNC_CHAR: sync_char_q <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// input register takes one bit transaction per cycle unless the framing stage is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= bit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bit_s1 <= line_bit;
		end
	end

	// lsb-first assembly: new bit enters at the top
	assign shifter_next = {bit_s1, shifter_q[BYTE_W-1:1]};
	assign parity_ok    = ^shifter_next;
	assign sync_hit     = parity_ok && (shifter_next[CHAR_W-1:0] == sync_char_q);
	assign count_inc    = count_q + CHAR_W'(1);

	sfr_crc16_byte u_crc (
		.rem      (crc_q),
		.data     (shifter_next),
		.poly     (crc_poly_q),
		.rem_next (crc_upd)
	);

	always_comb begin
		phase_next    = phase_q;
		held_seq_next = held_seq_q;
		held_len_next = held_len_q;
		count_next    = count_q;
		crc_next      = crc_q;
		res_hit       = 1'b0;
		res_status    = ST_SYNC_MISS;
		res_data      = '0;
		res_index     = '0;
		res_dvalid    = 1'b0;
		res_end       = 1'b1;
		res_seq       = '0;
		res_len       = '0;
		unique case (phase_q) inside
			PH_SYNC2: begin
				if (sync_hit) begin
					held_seq_next = '0;
					held_len_next = '0;
					phase_next    = PH_SEQ;
				end else begin
					phase_next = PH_SYNC1;
					res_hit    = 1'b1;
				end
			end
			PH_SEQ, PH_LEN: begin
				if (!parity_ok) begin
					// header parity fault reports what was held so far
					phase_next = PH_SYNC1;
					res_hit    = 1'b1;
					res_status = ST_PARITY;
					res_seq    = held_seq_q;
					res_len    = held_len_q;
				end else if (phase_q == PH_SEQ) begin
					held_seq_next = shifter_next[CHAR_W-1:0];
					phase_next    = PH_LEN;
				end else begin
					held_len_next = shifter_next[CHAR_W-1:0];
					count_next    = '0;
					crc_next      = '0;
					if (shifter_next[CHAR_W-1:0] == '0) begin
						// empty payload passes at once
						phase_next = PH_SYNC1;
						res_hit    = 1'b1;
						res_status = ST_CRC_PASS;
						res_seq    = held_seq_q;
					end else begin
						phase_next = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				crc_next   = crc_upd;
				count_next = count_inc;
				res_hit    = 1'b1;
				res_data   = shifter_next;
				res_index  = count_q;
				res_dvalid = 1'b1;
				res_seq    = held_seq_q;
				res_len    = held_len_q;
				if (count_inc >= held_len_q) begin
					// last byte carries the crc verdict
					phase_next = PH_SYNC1;
					res_status = (crc_upd == '0) ? ST_CRC_PASS : ST_CRC_FAIL;
				end else begin
					res_status = ST_PAYLOAD;
					res_end    = 1'b0;
				end
			end
			default: begin
				// hunting, also unused phase codes
				if (sync_hit) begin
					phase_next = PH_SYNC2;
				end else begin
					phase_next = PH_SYNC1;
					res_hit    = 1'b1;
				end
			end
		endcase
	end

	// framer state advances on every bit; byte decisions on the eighth bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q  <= '0;
			shifter_q  <= '0;
			phase_q    <= PH_SYNC1;
			held_seq_q <= '0;
			held_len_q <= '0;
			count_q    <= '0;
			crc_q      <= '0;
		end else if (advance && valid_s1) begin
			shifter_q <= shifter_next;
			bit_pos_q <= bit_pos_q + BITPOS_W'(1);
			if (bit_pos_q == '1) begin
				phase_q    <= phase_next;
				held_seq_q <= held_seq_next;
				held_len_q <= held_len_next;
				count_q    <= count_next;
				crc_q      <= crc_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && (bit_pos_q == '1) && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && (bit_pos_q == '1) && res_hit) begin
			status_q     <= res_status;
			data_byte_q  <= res_data;
			byte_index_q <= res_index;
			data_valid_q <= res_dvalid;
			frame_end_q  <= res_end;
			seq_q        <= res_seq;
			len_q        <= res_len;
		end
	end

	assign result_valid    = result_valid_q;
	assign status          = status_q;
	assign data_byte       = data_byte_q;
	assign byte_index      = byte_index_q;
	assign data_valid      = data_valid_q;
	assign frame_end       = frame_end_q;
	assign sequence_number = seq_q;
	assign frame_length    = len_q;

endmodule

// ===== design/sfr_crc16_byte.sv =====
// byte-wide crc-16 update, msb first, programmable polynomial
// depends on sfr_crc16_pkg for widths
module sfr_crc16_byte import sfr_crc16_pkg::*; (
	input  logic [CRC_W-1:0]  rem,
	input  logic [BYTE_W-1:0] data,
	input  logic [CRC_W-1:0]  poly,
	output logic [CRC_W-1:0]  rem_next
);

	always_comb begin
		logic [CRC_W-1:0] r;
		r = rem ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			if (r[CRC_W-1]) begin
				r = {r[CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				r = {r[CRC_W-2:0], 1'b0};
			end
		end
		rem_next = r;
	end

endmodule

// ===== tb/sv/serial_frame_receiver_crc16_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the serial frame receiver with crc-16 check:
// a bit-level frame decoder predicts every result, the checker compares them field by field
// depends on sfr_crc16_pkg and serial_frame_receiver_crc16_core
module serial_frame_receiver_crc16_core_tb;
	import sfr_crc16_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;   // cycles with no transaction at all
	localparam int PIPE_SETTLE    = 6;      // two-stage bit path plus margin
	localparam int RANDOM_BITS    = 200;
	localparam int PHASE_BITS     = 80;     // bits between reconfigurations

	// one result transaction as seen on the output ports
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] data_byte;
		logic [CHAR_W-1:0] byte_index;
		logic              data_valid;
		logic              frame_end;
		logic [CHAR_W-1:0] sequence_number;
		logic [CHAR_W-1:0] frame_length;
	} frame_result_t;

	// ways of breaking a frame header or body
	typedef enum int {
		FAULT_SYNC1_CHAR,
		FAULT_SYNC1_PARITY,
		FAULT_SYNC2_CHAR,
		FAULT_SYNC2_PARITY,
		FAULT_SEQ_PARITY,
		FAULT_LEN_PARITY,
		FAULT_TRUNCATED
	} frame_fault_e;

	logic                 clk;
	logic                 arst_n;
	logic                 bit_valid;
	logic                 bit_stall;
	logic                 line_bit;
	logic                 result_valid;
	logic                 result_stall;
	logic [STAT_W-1:0]    status;
	logic [BYTE_W-1:0]    data_byte;
	logic [CHAR_W-1:0]    byte_index;
	logic                 data_valid;
	logic                 frame_end;
	logic [CHAR_W-1:0]    sequence_number;
	logic [CHAR_W-1:0]    frame_length;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CRC_W-1:0]     cfg_data;

	serial_frame_receiver_crc16_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.bit_valid       (bit_valid),
		.bit_stall       (bit_stall),
		.line_bit        (line_bit),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.status          (status),
		.data_byte       (data_byte),
		.byte_index      (byte_index),
		.data_valid      (data_valid),
		.frame_end       (frame_end),
		.sequence_number (sequence_number),
		.frame_length    (frame_length),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// decoder copy of the configuration registers
	logic [CRC_W-1:0]   poly_q = CRC_POLY_RST;
	logic [CHAR_W-1:0]  sync_q = SYNC_CHAR_RST;

	// decoder copy of the framer state, reset values
	logic [BITPOS_W-1:0] bit_pos   = '0;
	logic [BYTE_W-1:0]   shifter   = '0;
	logic [PHASE_W-1:0]  phase     = PH_SYNC1;
	logic [CHAR_W-1:0]   held_seq  = '0;
	logic [CHAR_W-1:0]   held_len  = '0;
	logic [CHAR_W-1:0]   pay_cnt   = '0;
	logic [CRC_W-1:0]    crc_rem   = '0;

	frame_result_t pending_results[$];
	frame_result_t seen_r;
	frame_result_t want_r;

	int  err_count    = 0;
	int  results_seen = 0;
	int  bits_sent    = 0;
	int  cfg_writes   = 0;
	int  idle_cycles  = 0;
	int  stall_left   = 0;
	bit  quiet        = 1'b0;   // no idling on either side when set

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// crc-16, msb first, one byte at a time
	function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] rem,
			input logic [BYTE_W-1:0] b, input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = rem ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ((r << 1) ^ poly) : (r << 1);
		end
		return r;
	endfunction

	// seven-bit character with odd (good) or even (bad) parity in bit 7
	function automatic logic [BYTE_W-1:0] header_byte(input logic [CHAR_W-1:0] c,
			input logic good_parity);
		return {good_parity ? ~^c : ^c, c};
	endfunction

	// bit-level frame decoder: advances on every accepted line bit and queues the
	// result caused by a completed byte
	function automatic void frame_decode_bit(input logic b);
		logic [BYTE_W-1:0] bt;
		logic              par;
		logic              have;
		frame_result_t     r;
		shifter = {b, shifter[7:1]};
		if (bit_pos != 3'd7) begin
			bit_pos = bit_pos + 3'd1;
			return;
		end
		bit_pos = '0;
		bt      = shifter;
		par     = ^bt;
		have    = 1'b0;
		r       = '0;
		case (phase) inside
			PH_SYNC2: begin
				if (par && bt[6:0] == sync_q) begin
					held_seq = '0;
					held_len = '0;
					phase    = PH_SEQ;
				end else begin
					phase       = PH_SYNC1;
					r.status    = ST_SYNC_MISS;
					r.frame_end = 1'b1;
					have        = 1'b1;
				end
			end
			PH_SEQ, PH_LEN: begin
				if (!par) begin
					// header parity error keeps what was captured so far
					r.status          = ST_PARITY;
					r.frame_end       = 1'b1;
					r.sequence_number = held_seq;
					r.frame_length    = held_len;
					have              = 1'b1;
					phase             = PH_SYNC1;
				end else if (phase == PH_SEQ) begin
					held_seq = bt[6:0];
					phase    = PH_LEN;
				end else begin
					held_len = bt[6:0];
					pay_cnt  = '0;
					crc_rem  = '0;
					if (held_len == 0) begin
						// empty frame closes on its length byte with a pass
						r.status          = ST_CRC_PASS;
						r.frame_end       = 1'b1;
						r.sequence_number = held_seq;
						have              = 1'b1;
						phase             = PH_SYNC1;
					end else begin
						phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				r.byte_index      = pay_cnt;
				r.data_byte       = bt;
				r.data_valid      = 1'b1;
				r.sequence_number = held_seq;
				r.frame_length    = held_len;
				have              = 1'b1;
				crc_rem           = crc16_next(crc_rem, bt, poly_q);
				pay_cnt           = pay_cnt + 7'd1;
				if (pay_cnt >= held_len) begin
					r.status    = (crc_rem == 0) ? ST_CRC_PASS : ST_CRC_FAIL;
					r.frame_end = 1'b1;
					phase       = PH_SYNC1;
				end else begin
					r.status = ST_PAYLOAD;
				end
			end
			default: begin
				// hunting for the first sync character
				if (par && bt[6:0] == sync_q) begin
					phase = PH_SYNC2;
				end else begin
					phase       = PH_SYNC1;
					r.status    = ST_SYNC_MISS;
					r.frame_end = 1'b1;
					have        = 1'b1;
				end
			end
		endcase
		if (have) begin
			pending_results.push_back(r);
		end
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_error($sformatf("result %0d %s got 0x%0h expected 0x%0h",
				results_seen, name, got, want));
		end
	endtask

	// result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			seen_r = '{status, data_byte, byte_index, data_valid, frame_end,
				sequence_number, frame_length};
			if (pending_results.size() == 0) begin
				report_error($sformatf("unexpected result, status %0d data 0x%0h",
					status, data_byte));
			end else begin
				want_r = pending_results.pop_front();
				compare_field("status", 16'(seen_r.status), 16'(want_r.status));
				compare_field("data_byte", 16'(seen_r.data_byte), 16'(want_r.data_byte));
				compare_field("byte_index", 16'(seen_r.byte_index),
					16'(want_r.byte_index));
				compare_field("data_valid", 16'(seen_r.data_valid),
					16'(want_r.data_valid));
				compare_field("frame_end", 16'(seen_r.frame_end), 16'(want_r.frame_end));
				compare_field("sequence_number", 16'(seen_r.sequence_number),
					16'(want_r.sequence_number));
				compare_field("frame_length", 16'(seen_r.frame_length),
					16'(want_r.frame_length));
			end
			results_seen++;
		end
	end

	// watchdog: ends the run when no transaction of any kind happens for too long
	always @(posedge clk) begin
		if ((bit_valid && !bit_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				WATCHDOG_LIMIT, pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				result_stall <= 1'b0;
			end else if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 4);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// one line bit transaction, with an occasional sender gap;
	// valid stays high on return so back-to-back bits need no drop
	task automatic send_bit(input logic b);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				bit_valid <= 1'b0;
			end
		end
		@(negedge clk);
		bit_valid <= 1'b1;
		line_bit  <= b;
		@(posedge clk);
		while (bit_stall) begin
			@(posedge clk);
		end
		frame_decode_bit(b);
		bits_sent++;
	endtask

	// bytes go out lsb first
	task automatic send_byte(input logic [BYTE_W-1:0] v);
		for (int i = 0; i < BYTE_W; i++) begin
			send_bit(v[i]);
		end
	endtask

	// pad with random bits until the receiver is back on a byte boundary
	task automatic align_to_byte();
		while (bit_pos != 0) begin
			send_bit(1'($urandom));
		end
	endtask

	// complete frame; when it has two or more payload bytes, the last two carry the crc so
	// the remainder ends at zero, and without crc_ok the last byte is then corrupted
	task automatic send_frame(input logic [CHAR_W-1:0] seq, input logic [CHAR_W-1:0] len,
			input logic crc_ok);
		logic [CRC_W-1:0]  rem;
		logic [CRC_W-1:0]  crc_word;
		logic [BYTE_W-1:0] d;
		int                flen;
		flen     = int'(len);
		rem      = '0;
		crc_word = '0;
		align_to_byte();
		send_byte(header_byte(sync_q, 1'b1));
		send_byte(header_byte(sync_q, 1'b1));
		send_byte(header_byte(seq, 1'b1));
		send_byte(header_byte(len, 1'b1));
		for (int n = 0; n < flen; n++) begin
			if (flen >= 2 && n == flen - 2) begin
				crc_word = rem;
			end
			if (flen < 2 || n < flen - 2) begin
				d = 8'($urandom);
			end else if (n == flen - 2) begin
				d = crc_word[15:8];
			end else begin
				d = crc_word[7:0];
			end
			if (!crc_ok && flen >= 2 && n == flen - 1) begin
				d = d ^ 8'($urandom_range(1, 255));
			end
			send_byte(d);
			rem = crc16_next(rem, d, poly_q);
		end
	endtask

	// broken header or cut-off frame
	task automatic send_frame_fault(input frame_fault_e fault);
		logic [CHAR_W-1:0] other;
		int                flen;
		int                cut;
		other = sync_q ^ 7'($urandom_range(1, 127));
		align_to_byte();
		case (fault)
			FAULT_SYNC1_CHAR:   send_byte(header_byte(other, 1'b1));
			FAULT_SYNC1_PARITY: send_byte(header_byte(sync_q, 1'b0));
			FAULT_SYNC2_CHAR: begin
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(other, 1'b1));
			end
			FAULT_SYNC2_PARITY: begin
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(sync_q, 1'b0));
			end
			FAULT_SEQ_PARITY: begin
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(7'($urandom), 1'b0));
			end
			FAULT_LEN_PARITY: begin
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(7'($urandom), 1'b1));
				send_byte(header_byte(7'($urandom), 1'b0));
			end
			default: begin
				// payload cut short; whatever follows is taken as payload
				flen = $urandom_range(3, 20);
				cut  = $urandom_range(0, flen - 1);
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(sync_q, 1'b1));
				send_byte(header_byte(7'($urandom), 1'b1));
				send_byte(header_byte(7'(flen), 1'b1));
				repeat (cut) send_byte(8'($urandom));
			end
		endcase
	endtask

	// stop sending and wait until the receiver has nothing left in flight
	task automatic wait_receiver_idle();
		@(negedge clk);
		bit_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// register write; only called with the receiver idle
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == REG_CRC_POLY) begin
			poly_q = value;
		end else begin
			sync_q = value[CHAR_W-1:0];
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic reconfigure(input logic [CRC_W-1:0] poly, input logic [CHAR_W-1:0] sync);
		wait_receiver_idle();
		cfg_write(REG_CRC_POLY, poly);
		cfg_write(REG_SYNC_CHAR, {9'd0, sync});
	endtask

	// reset configuration: empty frame, passing and failing frames, all-ones fields
	task automatic test_reset_defaults();
		send_frame(7'd0, 7'd0, 1'b1);
		send_frame(7'd1, 7'd2, 1'b1);
		send_frame(7'd2, 7'd3, 1'b0);
		send_frame(7'h7f, 7'd5, 1'b1);
		send_frame(7'd5, 7'd1, 1'b1);
		send_byte(8'hff);
		send_byte(8'h00);
	endtask

	// every kind of header fault, a truncated frame, plus a byte left incomplete across a frame
	task automatic test_header_faults();
		send_frame_fault(FAULT_SYNC1_CHAR);
		send_frame_fault(FAULT_SYNC1_PARITY);
		send_frame_fault(FAULT_SYNC2_CHAR);
		send_frame_fault(FAULT_SYNC2_PARITY);
		send_frame_fault(FAULT_SEQ_PARITY);
		send_frame_fault(FAULT_LEN_PARITY);
		send_frame_fault(FAULT_TRUNCATED);
		// three lone bits, then the next frame is padded back into alignment
		repeat (3) send_bit(1'b1);
		send_frame(7'd9, 7'd4, 1'b1);
	endtask

	// register values at both ends of their range
	task automatic test_config_extremes();
		reconfigure(16'h0000, 7'd0);
		send_frame(7'd3, 7'd4, 1'b1);
		send_frame(7'd4, 7'd3, 1'b0);
		send_frame_fault(FAULT_SYNC2_PARITY);
		reconfigure(16'hffff, 7'h7f);
		send_frame(7'd6, 7'd6, 1'b1);
		send_frame(7'd7, 7'd2, 1'b0);
		send_frame_fault(FAULT_SEQ_PARITY);
	endtask

	// mostly well-formed frames with random content, the rest faults and line noise;
	// registers change every few dozen bits
	task automatic test_random_traffic();
		int start_bits;
		int phase_start;
		int pick;
		logic [CHAR_W-1:0] len;
		start_bits  = bits_sent;
		phase_start = bits_sent;
		while (bits_sent - start_bits < RANDOM_BITS) begin
			if (bits_sent - phase_start >= PHASE_BITS) begin
				case ($urandom_range(0, 3))
					0:       reconfigure(CRC_POLY_RST, SYNC_CHAR_RST);
					1:       reconfigure(16'hffff, 7'($urandom));
					default: reconfigure(16'($urandom), 7'($urandom));
				endcase
				phase_start = bits_sent;
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(9, 40))
					: 7'($urandom_range(0, 8));
				send_frame(7'($urandom), len, $urandom_range(0, 4) != 0);
			end else if (pick < 80) begin
				send_frame_fault(frame_fault_e'($urandom_range(0, 6)));
			end else if (pick < 90) begin
				send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 13)) send_bit(1'($urandom));
			end
		end
	endtask

	// back to reset values and full rate on both sides
	task automatic test_full_rate();
		reconfigure(CRC_POLY_RST, SYNC_CHAR_RST);
		quiet = 1'b1;
		repeat (2) begin
			send_frame(7'($urandom), 7'($urandom_range(0, 10)), $urandom_range(0, 3) != 0);
		end
		send_frame_fault(FAULT_LEN_PARITY);
		send_frame(7'd0, 7'd3, 1'b1);
	endtask

	initial begin
		arst_n    = 1'b0;
		bit_valid = 1'b0;
		line_bit  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CRC_POLY;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_header_faults();
		test_config_extremes();
		test_random_traffic();
		test_full_rate();

		// drain everything, then let the pipeline run a little longer
		wait_receiver_idle();
		repeat (PIPE_SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_error($sformatf("%0d expected results never arrived",
				pending_results.size()));
		end

		$display("run covered %0d line bits and %0d checked results over %0d register writes",
			bits_sent, results_seen, cfg_writes);
		$display("frames, header faults, noise and misaligned bits under random stalls; %0d errors",
			err_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
